[rtl/assert_macros.svh]
// Assertion macros used by the top level of the plane fit core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lspf_pkg.sv]
// Package with types, constants and the solve program of the plane fit core.
`default_nettype none
package lspf_pkg;

	localparam int COORD_BITS  = 20;
	localparam int COUNT_BITS  = 20;
	localparam int NORMAL_FRAC = 30;
	localparam int CNT_W       = COUNT_BITS + 1;
	localparam int SUM1_W      = 48;
	localparam int SUM2_W      = 64;
	localparam int BIG_W       = 448;
	localparam int ITER_W      = $clog2(BIG_W);
	localparam int SQ_IN_W     = 68;
	localparam int SQ_OUT_W    = SQ_IN_W / 2;
	localparam int SQ_REM_W    = SQ_OUT_W + 3;
	localparam int OUT_W       = 32;
	localparam int RADDR_W     = 5;
	localparam int REG_DEPTH   = 1 << RADDR_W;
	localparam int PC_W        = 7;
	localparam int OP_W        = 4;

	localparam logic [OP_W-1:0] OP_CLR = 4'd0;
	localparam logic [OP_W-1:0] OP_LD  = 4'd1;
	localparam logic [OP_W-1:0] OP_ADD = 4'd2;
	localparam logic [OP_W-1:0] OP_SUB = 4'd3;
	localparam logic [OP_W-1:0] OP_MUL = 4'd4;
	localparam logic [OP_W-1:0] OP_CHK = 4'd5;
	localparam logic [OP_W-1:0] OP_SGN = 4'd6;
	localparam logic [OP_W-1:0] OP_RR  = 4'd7;
	localparam logic [OP_W-1:0] OP_END = 4'd8;

	localparam logic [RADDR_W-1:0] R_N    = 5'd0;
	localparam logic [RADDR_W-1:0] R_SX   = 5'd1;
	localparam logic [RADDR_W-1:0] R_SY   = 5'd2;
	localparam logic [RADDR_W-1:0] R_SZ   = 5'd3;
	localparam logic [RADDR_W-1:0] R_SYY  = 5'd4;
	localparam logic [RADDR_W-1:0] R_SYZ  = 5'd5;
	localparam logic [RADDR_W-1:0] R_SZZ  = 5'd6;
	localparam logic [RADDR_W-1:0] R_SXY  = 5'd7;
	localparam logic [RADDR_W-1:0] R_SXZ  = 5'd8;
	localparam logic [RADDR_W-1:0] R_SC   = 5'd9;
	localparam logic [RADDR_W-1:0] R_FOUR = 5'd10;
	localparam logic [RADDR_W-1:0] R_CYY  = 5'd11;
	localparam logic [RADDR_W-1:0] R_CYZ  = 5'd12;
	localparam logic [RADDR_W-1:0] R_CZZ  = 5'd13;
	localparam logic [RADDR_W-1:0] R_CXY  = 5'd14;
	localparam logic [RADDR_W-1:0] R_CXZ  = 5'd15;
	localparam logic [RADDR_W-1:0] R_D    = 5'd16;
	localparam logic [RADDR_W-1:0] R_A    = 5'd17;
	localparam logic [RADDR_W-1:0] R_B    = 5'd18;
	localparam logic [RADDR_W-1:0] R_R2   = 5'd19;
	localparam logic [RADDR_W-1:0] R_T    = 5'd20;
	localparam logic [RADDR_W-1:0] R_U    = 5'd21;
	localparam logic [RADDR_W-1:0] R_NUM  = 5'd22;

	localparam logic [RADDR_W-1:0] O_NX = 5'd0;
	localparam logic [RADDR_W-1:0] O_NY = 5'd1;
	localparam logic [RADDR_W-1:0] O_NZ = 5'd2;
	localparam logic [RADDR_W-1:0] O_D  = 5'd3;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [RADDR_W-1:0] dst;
		logic [RADDR_W-1:0] a;
		logic [RADDR_W-1:0] b;
	} instr_t;

	typedef struct packed {
		logic   issue;
		instr_t ins;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic sing;
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [SUM1_W-1:0] sx;
		logic [SUM1_W-1:0] sy;
		logic [SUM1_W-1:0] sz;
		logic [SUM2_W-1:0] syy;
		logic [SUM2_W-1:0] syz;
		logic [SUM2_W-1:0] szz;
		logic [SUM2_W-1:0] sxy;
		logic [SUM2_W-1:0] sxz;
	} sums_t;

	typedef struct packed {
		logic [OUT_W-1:0] nx;
		logic [OUT_W-1:0] ny;
		logic [OUT_W-1:0] nz;
		logic [OUT_W-1:0] d;
		logic             sing;
	} res_t;

	function automatic instr_t mk(input logic [OP_W-1:0] op, input logic [RADDR_W-1:0] dst,
			input logic [RADDR_W-1:0] a, input logic [RADDR_W-1:0] b);
		instr_t i;
		i.op  = op;
		i.dst = dst;
		i.a   = a;
		i.b   = b;
		return i;
	endfunction

	// Solve sequence: centered moments, determinant check, normal and offset.
	function automatic instr_t prog(input logic [PC_W-1:0] pc);
		instr_t i;
		case (pc)
			7'd0:  i = mk(OP_CLR, R_N, R_N, R_N);
			7'd1:  i = mk(OP_LD, R_N, R_N, R_N);
			7'd2:  i = mk(OP_LD, R_SX, R_SX, R_N);
			7'd3:  i = mk(OP_LD, R_SY, R_SY, R_N);
			7'd4:  i = mk(OP_LD, R_SZ, R_SZ, R_N);
			7'd5:  i = mk(OP_LD, R_SYY, R_SYY, R_N);
			7'd6:  i = mk(OP_LD, R_SYZ, R_SYZ, R_N);
			7'd7:  i = mk(OP_LD, R_SZZ, R_SZZ, R_N);
			7'd8:  i = mk(OP_LD, R_SXY, R_SXY, R_N);
			7'd9:  i = mk(OP_LD, R_SXZ, R_SXZ, R_N);
			7'd10: i = mk(OP_LD, R_SC, R_SC, R_N);
			7'd11: i = mk(OP_LD, R_FOUR, R_FOUR, R_N);
			7'd12: i = mk(OP_MUL, R_T, R_N, R_SYY);
			7'd13: i = mk(OP_MUL, R_U, R_SY, R_SY);
			7'd14: i = mk(OP_SUB, R_CYY, R_T, R_U);
			7'd15: i = mk(OP_MUL, R_T, R_N, R_SYZ);
			7'd16: i = mk(OP_MUL, R_U, R_SY, R_SZ);
			7'd17: i = mk(OP_SUB, R_CYZ, R_T, R_U);
			7'd18: i = mk(OP_MUL, R_T, R_N, R_SZZ);
			7'd19: i = mk(OP_MUL, R_U, R_SZ, R_SZ);
			7'd20: i = mk(OP_SUB, R_CZZ, R_T, R_U);
			7'd21: i = mk(OP_MUL, R_T, R_N, R_SXY);
			7'd22: i = mk(OP_MUL, R_U, R_SX, R_SY);
			7'd23: i = mk(OP_SUB, R_CXY, R_T, R_U);
			7'd24: i = mk(OP_MUL, R_T, R_N, R_SXZ);
			7'd25: i = mk(OP_MUL, R_U, R_SX, R_SZ);
			7'd26: i = mk(OP_SUB, R_CXZ, R_T, R_U);
			7'd27: i = mk(OP_MUL, R_T, R_CYY, R_CZZ);
			7'd28: i = mk(OP_MUL, R_U, R_CYZ, R_CYZ);
			7'd29: i = mk(OP_SUB, R_D, R_T, R_U);
			7'd30: i = mk(OP_CHK, R_D, R_D, R_D);
			7'd31: i = mk(OP_MUL, R_T, R_CXY, R_CZZ);
			7'd32: i = mk(OP_MUL, R_U, R_CXZ, R_CYZ);
			7'd33: i = mk(OP_SUB, R_A, R_T, R_U);
			7'd34: i = mk(OP_MUL, R_T, R_CXZ, R_CYY);
			7'd35: i = mk(OP_MUL, R_U, R_CXY, R_CYZ);
			7'd36: i = mk(OP_SUB, R_B, R_T, R_U);
			7'd37: i = mk(OP_MUL, R_R2, R_D, R_D);
			7'd38: i = mk(OP_MUL, R_T, R_A, R_A);
			7'd39: i = mk(OP_ADD, R_R2, R_R2, R_T);
			7'd40: i = mk(OP_MUL, R_T, R_B, R_B);
			7'd41: i = mk(OP_ADD, R_R2, R_R2, R_T);
			7'd42: i = mk(OP_MUL, R_NUM, R_D, R_D);
			7'd43: i = mk(OP_MUL, R_NUM, R_NUM, R_SC);
			7'd44: i = mk(OP_RR, O_NX, R_NUM, R_R2);
			7'd45: i = mk(OP_SGN, O_NY, R_A, R_A);
			7'd46: i = mk(OP_MUL, R_NUM, R_A, R_A);
			7'd47: i = mk(OP_MUL, R_NUM, R_NUM, R_SC);
			7'd48: i = mk(OP_RR, O_NY, R_NUM, R_R2);
			7'd49: i = mk(OP_SGN, O_NZ, R_B, R_B);
			7'd50: i = mk(OP_MUL, R_NUM, R_B, R_B);
			7'd51: i = mk(OP_MUL, R_NUM, R_NUM, R_SC);
			7'd52: i = mk(OP_RR, O_NZ, R_NUM, R_R2);
			7'd53: i = mk(OP_MUL, R_NUM, R_D, R_SX);
			7'd54: i = mk(OP_MUL, R_T, R_A, R_SY);
			7'd55: i = mk(OP_SUB, R_NUM, R_NUM, R_T);
			7'd56: i = mk(OP_MUL, R_T, R_B, R_SZ);
			7'd57: i = mk(OP_SUB, R_NUM, R_NUM, R_T);
			7'd58: i = mk(OP_SGN, O_D, R_NUM, R_NUM);
			7'd59: i = mk(OP_MUL, R_NUM, R_NUM, R_NUM);
			7'd60: i = mk(OP_MUL, R_NUM, R_NUM, R_FOUR);
			7'd61: i = mk(OP_MUL, R_T, R_N, R_N);
			7'd62: i = mk(OP_MUL, R_T, R_T, R_R2);
			7'd63: i = mk(OP_RR, O_D, R_NUM, R_T);
			default: i = mk(OP_END, R_N, R_N, R_N);
		endcase
		return i;
	endfunction

endpackage
`default_nettype wire

[rtl/lspf_accum.sv]
// Point accumulator holding the count and the first and second order sums.
`default_nettype none
module lspf_accum (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             clr,
	input  wire logic [lspf_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic [lspf_pkg::COORD_BITS-1:0] pos_y,
	input  wire logic [lspf_pkg::COORD_BITS-1:0] pos_z,
	output lspf_pkg::sums_t                       sums
);

	localparam int CB = lspf_pkg::COORD_BITS;
	localparam int PW = 2 * CB;

	logic signed [CB-1:0] cx, cy, cz;
	logic signed [PW-1:0] pyy, pyz, pzz, pxy, pxz;
	lspf_pkg::sums_t sums_q;
	logic room;

	function automatic logic [lspf_pkg::SUM1_W-1:0] ext1(input logic [CB-1:0] v);
		return {{(lspf_pkg::SUM1_W-CB){v[CB-1]}}, v};
	endfunction

	function automatic logic [lspf_pkg::SUM2_W-1:0] ext2(input logic [PW-1:0] v);
		return {{(lspf_pkg::SUM2_W-PW){v[PW-1]}}, v};
	endfunction

	always_comb begin
		cx   = pos_x;
		cy   = pos_y;
		cz   = pos_z;
		pyy  = cy * cy;
		pyz  = cy * cz;
		pzz  = cz * cz;
		pxy  = cx * cy;
		pxz  = cx * cz;
		room = sums_q.count < lspf_pkg::CNT_W'(1 << lspf_pkg::COUNT_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (clr) begin
			sums_q <= '0;
		end else if (en && room) begin
			sums_q.count <= sums_q.count + lspf_pkg::CNT_W'(1);
			sums_q.sx    <= sums_q.sx + ext1(cx);
			sums_q.sy    <= sums_q.sy + ext1(cy);
			sums_q.sz    <= sums_q.sz + ext1(cz);
			sums_q.syy   <= sums_q.syy + ext2(pyy);
			sums_q.syz   <= sums_q.syz + ext2(pyz);
			sums_q.szz   <= sums_q.szz + ext2(pzz);
			sums_q.sxy   <= sums_q.sxy + ext2(pxy);
			sums_q.sxz   <= sums_q.sxz + ext2(pxz);
		end
	end

	assign sums = sums_q;

endmodule
`default_nettype wire

[rtl/lspf_alu.sv]
// Wide integer datapath: register memory, bit-serial multiply, divide and square root.
`default_nettype none
module lspf_alu (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  lspf_pkg::cmd_t  cmd,
	input  lspf_pkg::sums_t sums,
	output lspf_pkg::status_t st,
	output lspf_pkg::res_t    res
);

	localparam int W  = lspf_pkg::BIG_W;
	localparam int IW = lspf_pkg::ITER_W;
	localparam int SI = lspf_pkg::SQ_IN_W;
	localparam int SO = lspf_pkg::SQ_OUT_W;
	localparam int SR = lspf_pkg::SQ_REM_W;
	localparam int OW = lspf_pkg::OUT_W;

	localparam logic [3:0] D_IDLE = 4'd0;
	localparam logic [3:0] D_RD   = 4'd1;
	localparam logic [3:0] D_MUL  = 4'd2;
	localparam logic [3:0] D_DIV  = 4'd3;
	localparam logic [3:0] D_SQI  = 4'd4;
	localparam logic [3:0] D_SQ   = 4'd5;
	localparam logic [3:0] D_FIN  = 4'd6;
	localparam logic [3:0] D_WB   = 4'd7;
	localparam logic [3:0] D_DONE = 4'd8;

	logic [W-1:0] mem [0:lspf_pkg::REG_DEPTH-1];
	logic [W-1:0] ra_q, rb_q;
	lspf_pkg::instr_t ins_q;
	logic [3:0] ds_q;
	logic [W-1:0] acc_q, mcand_q, mplier_q, rem_q;
	logic [IW-1:0] cnt_q;
	logic neg_res_q;
	logic [3:0] neg_q;
	logic sing_q;
	logic [OW-1:0] res_q [0:3];
	logic [SI-1:0] src_q;
	logic [SO-1:0] root_q;
	logic [SR-1:0] srem_q;
	logic big_q;

	logic [W-1:0] abs_a, abs_b, mul_next, ld_val, wdata;
	logic [W:0] rem_sh, rem_sub;
	logic div_ge;
	logic [SR-1:0] sq_rem2, sq_trial;
	logic sq_ge;
	logic [SO:0] mag;
	logic [OW-1:0] out_val;
	logic out_neg;

	function automatic logic [W-1:0] ext1(input logic [lspf_pkg::SUM1_W-1:0] v);
		return {{(W-lspf_pkg::SUM1_W){v[lspf_pkg::SUM1_W-1]}}, v};
	endfunction

	function automatic logic [W-1:0] ext2(input logic [lspf_pkg::SUM2_W-1:0] v);
		return {{(W-lspf_pkg::SUM2_W){v[lspf_pkg::SUM2_W-1]}}, v};
	endfunction

	always_comb begin
		abs_a    = ra_q[W-1] ? (~ra_q + W'(1)) : ra_q;
		abs_b    = rb_q[W-1] ? (~rb_q + W'(1)) : rb_q;
		mul_next = {acc_q[W-2:0], 1'b0} + (mplier_q[W-1] ? mcand_q : '0);
		rem_sh   = {rem_q, mplier_q[W-1]};
		div_ge   = rem_sh >= {1'b0, mcand_q};
		rem_sub  = rem_sh - {1'b0, mcand_q};
		sq_rem2  = {srem_q[SR-3:0], src_q[SI-1 -: 2]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_rem2 >= sq_trial;
		wdata    = neg_res_q ? (~acc_q + W'(1)) : acc_q;
		out_neg  = neg_q[ins_q.dst[1:0]];
		if (big_q) begin
			mag = (SO+1)'(1) << (SO - 1);
		end else begin
			mag = ({1'b0, root_q} + (SO+1)'(1)) >> 1;
		end
		if (out_neg && mag > ((SO+1)'(1) << (OW - 1))) begin
			mag = (SO+1)'(1) << (OW - 1);
		end else if (!out_neg && mag > (((SO+1)'(1) << (OW - 1)) - (SO+1)'(1))) begin
			mag = ((SO+1)'(1) << (OW - 1)) - (SO+1)'(1);
		end
		out_val = out_neg ? (~mag[OW-1:0] + OW'(1)) : mag[OW-1:0];
		case (ins_q.a)
			lspf_pkg::R_N:    ld_val = W'(sums.count);
			lspf_pkg::R_SX:   ld_val = ext1(sums.sx);
			lspf_pkg::R_SY:   ld_val = ext1(sums.sy);
			lspf_pkg::R_SZ:   ld_val = ext1(sums.sz);
			lspf_pkg::R_SYY:  ld_val = ext2(sums.syy);
			lspf_pkg::R_SYZ:  ld_val = ext2(sums.syz);
			lspf_pkg::R_SZZ:  ld_val = ext2(sums.szz);
			lspf_pkg::R_SXY:  ld_val = ext2(sums.sxy);
			lspf_pkg::R_SXZ:  ld_val = ext2(sums.sxz);
			lspf_pkg::R_SC:   ld_val = W'(1) << (2 * lspf_pkg::NORMAL_FRAC + 2);
			lspf_pkg::R_FOUR: ld_val = W'(4);
			default:          ld_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ds_q == D_WB) begin
			mem[ins_q.dst] <= wdata;
		end
		if (cmd.issue) begin
			ra_q <= mem[cmd.ins.a];
			rb_q <= mem[cmd.ins.b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q      <= D_IDLE;
			ins_q     <= '0;
			acc_q     <= '0;
			mcand_q   <= '0;
			mplier_q  <= '0;
			rem_q     <= '0;
			cnt_q     <= '0;
			neg_res_q <= 1'b0;
			neg_q     <= '0;
			sing_q    <= 1'b0;
			res_q     <= '{default: '0};
			src_q     <= '0;
			root_q    <= '0;
			srem_q    <= '0;
			big_q     <= 1'b0;
		end else begin
			unique case (ds_q)
				D_IDLE: begin
					if (cmd.issue) begin
						ins_q <= cmd.ins;
						ds_q  <= D_RD;
					end
				end
				D_RD: begin
					unique case (ins_q.op)
						lspf_pkg::OP_CLR: begin
							res_q  <= '{default: '0};
							neg_q  <= '0;
							sing_q <= 1'b0;
							ds_q   <= D_DONE;
						end
						lspf_pkg::OP_LD: begin
							acc_q     <= ld_val;
							neg_res_q <= 1'b0;
							ds_q      <= D_WB;
						end
						lspf_pkg::OP_ADD: begin
							acc_q     <= ra_q + rb_q;
							neg_res_q <= 1'b0;
							ds_q      <= D_WB;
						end
						lspf_pkg::OP_SUB: begin
							acc_q     <= ra_q - rb_q;
							neg_res_q <= 1'b0;
							ds_q      <= D_WB;
						end
						lspf_pkg::OP_MUL: begin
							acc_q     <= '0;
							mcand_q   <= abs_a;
							mplier_q  <= abs_b;
							neg_res_q <= ra_q[W-1] ^ rb_q[W-1];
							cnt_q     <= IW'(W - 1);
							ds_q      <= D_MUL;
						end
						lspf_pkg::OP_CHK: begin
							sing_q <= ra_q[W-1] || (ra_q == '0);
							ds_q   <= D_DONE;
						end
						lspf_pkg::OP_SGN: begin
							neg_q[ins_q.dst[1:0]] <= !ra_q[W-1] && (ra_q != '0);
							ds_q <= D_DONE;
						end
						lspf_pkg::OP_RR: begin
							mplier_q <= ra_q;
							mcand_q  <= rb_q;
							rem_q    <= '0;
							cnt_q    <= IW'(W - 1);
							ds_q     <= D_DIV;
						end
						default: begin
							ds_q <= D_DONE;
						end
					endcase
				end
				D_MUL: begin
					acc_q    <= mul_next;
					mplier_q <= {mplier_q[W-2:0], 1'b0};
					cnt_q    <= cnt_q - IW'(1);
					if (cnt_q == '0) begin
						ds_q <= D_WB;
					end
				end
				D_DIV: begin
					rem_q    <= div_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
					mplier_q <= {mplier_q[W-2:0], div_ge};
					cnt_q    <= cnt_q - IW'(1);
					if (cnt_q == '0) begin
						ds_q <= D_SQI;
					end
				end
				D_SQI: begin
					big_q  <= |mplier_q[W-1:SI];
					src_q  <= mplier_q[SI-1:0];
					root_q <= '0;
					srem_q <= '0;
					cnt_q  <= IW'(SO - 1);
					ds_q   <= D_SQ;
				end
				D_SQ: begin
					srem_q <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
					root_q <= {root_q[SO-2:0], sq_ge};
					src_q  <= {src_q[SI-3:0], 2'b00};
					cnt_q  <= cnt_q - IW'(1);
					if (cnt_q == '0) begin
						ds_q <= D_FIN;
					end
				end
				D_FIN: begin
					res_q[ins_q.dst[1:0]] <= out_val;
					ds_q <= D_DONE;
				end
				D_WB: begin
					ds_q <= D_DONE;
				end
				D_DONE: begin
					ds_q <= D_IDLE;
				end
				default: begin
					ds_q <= D_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		st.done  = ds_q == D_DONE;
		st.sing  = sing_q;
		res.nx   = res_q[0];
		res.ny   = res_q[1];
		res.nz   = res_q[2];
		res.d    = res_q[3];
		res.sing = sing_q;
	end

endmodule
`default_nettype wire

[rtl/lspf_ctrl.sv]
// Controller that accepts points and steps the datapath through the solve program.
`default_nettype none
module lspf_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pt_valid,
	input  wire logic       pt_last,
	input  wire logic       out_free,
	input  lspf_pkg::status_t st,
	output logic            pt_ready,
	output lspf_pkg::cmd_t  cmd,
	output logic            publish
);

	localparam logic [1:0] C_ACC   = 2'd0;
	localparam logic [1:0] C_ISSUE = 2'd1;
	localparam logic [1:0] C_WAIT  = 2'd2;
	localparam logic [1:0] C_END   = 2'd3;

	logic [1:0] state_q;
	logic [lspf_pkg::PC_W-1:0] pc_q;
	lspf_pkg::instr_t cur;

	always_comb begin
		cur       = lspf_pkg::prog(pc_q);
		pt_ready  = state_q == C_ACC;
		cmd.issue = (state_q == C_ISSUE) && (cur.op != lspf_pkg::OP_END);
		cmd.ins   = cur;
		publish   = (state_q == C_END) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_ACC;
			pc_q    <= '0;
		end else begin
			unique case (state_q)
				C_ACC: begin
					if (pt_valid && pt_last) begin
						pc_q    <= '0;
						state_q <= C_ISSUE;
					end
				end
				C_ISSUE: begin
					state_q <= (cur.op == lspf_pkg::OP_END) ? C_END : C_WAIT;
				end
				C_WAIT: begin
					if (st.done) begin
						if (st.sing) begin
							state_q <= C_END;
						end else begin
							pc_q    <= pc_q + lspf_pkg::PC_W'(1);
							state_q <= C_ISSUE;
						end
					end
				end
				C_END: begin
					if (out_free) begin
						state_q <= C_ACC;
					end
				end
				default: begin
					state_q <= C_ACC;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/least_squares_plane_fit_core.sv]
// Top level of the least-squares plane fit core.
//
//   Channel  Signals                                   Direction
//   pt       pt_valid pt_ready pos_x pos_y pos_z last  request in
//   res      res_valid res_ready normal_x normal_y     request out
//            normal_z offset_d singular
//
// A point is taken every cycle while the core accumulates.
// A point flagged last starts the solve on the shared 448-bit bit-serial multiply,
// divide and square root unit: 32 multiplies and 4 divides, fewer for a singular cloud.
// No points are taken during the solve; the result waits in an output register while
// the next cloud streams in. Reset clears all sums and control state.
`default_nettype none
`include "assert_macros.svh"
module least_squares_plane_fit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pt_valid,
	output logic             pt_ready,
	input  wire logic [19:0] pos_x,
	input  wire logic [19:0] pos_y,
	input  wire logic [19:0] pos_z,
	input  wire logic        last,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [31:0]      normal_x,
	output logic [31:0]      normal_y,
	output logic [31:0]      normal_z,
	output logic [31:0]      offset_d,
	output logic             singular
);

	lspf_pkg::sums_t   sums;
	lspf_pkg::cmd_t    cmd;
	lspf_pkg::status_t st;
	lspf_pkg::res_t    res;
	lspf_pkg::res_t    out_q;
	logic res_valid_q;
	logic out_free;
	logic publish;
	logic pt_acc;

	assign pt_acc   = pt_valid && pt_ready;
	assign out_free = !res_valid_q || res_ready;

	lspf_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pt_acc),
		.clr    (publish),
		.pos_x  (pos_x[lspf_pkg::COORD_BITS-1:0]),
		.pos_y  (pos_y[lspf_pkg::COORD_BITS-1:0]),
		.pos_z  (pos_z[lspf_pkg::COORD_BITS-1:0]),
		.sums   (sums)
	);

	lspf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_last  (last),
		.out_free (out_free),
		.st       (st),
		.pt_ready (pt_ready),
		.cmd      (cmd),
		.publish  (publish)
	);

	lspf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sums   (sums),
		.st     (st),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (publish) begin
			res_valid_q <= 1'b1;
			out_q       <= res;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign normal_x  = out_q.nx;
	assign normal_y  = out_q.ny;
	assign normal_z  = out_q.nz;
	assign offset_d  = out_q.d;
	assign singular  = out_q.sing;

	`ASSERT_IMPL(a_publish_slot_free, clk, arst_n, publish, !res_valid_q || res_ready, "result published over a pending result")
	`ASSERT_NEXT(a_sums_cleared, clk, arst_n, publish, sums.count == '0, "sums not cleared after a result")
	`ASSERT_NEXT(a_last_starts_solve, clk, arst_n, pt_acc && last, !pt_ready, "point taken after the last point before the solve")

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the least-squares plane fit core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	localparam int CYCLE_LIMIT = 80000000;
	localparam int HOLD_CYCLES = 40000;

	typedef logic [447:0] wide_t;

	typedef struct {
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
		logic [31:0] d;
		logic        sing;
	} plane_t;

	typedef enum int {CLOUD_PLANAR, CLOUD_UNIFORM, CLOUD_LINE, CLOUD_CORNERS} cloud_kind_t;

	logic        clk;
	logic        arst_n;
	logic        pt_valid;
	logic        pt_ready;
	logic [19:0] pos_x;
	logic [19:0] pos_y;
	logic [19:0] pos_z;
	logic        last;
	logic        res_valid;
	logic        res_ready;
	logic [31:0] normal_x;
	logic [31:0] normal_y;
	logic [31:0] normal_z;
	logic [31:0] offset_d;
	logic        singular;

	plane_t      plane_q[$];
	int          fail_count;
	int          cycle_count;
	bit          quiet;
	int          hold_request;

	logic [63:0] acc_x, acc_y, acc_z, acc_yy, acc_yz, acc_zz, acc_xy, acc_xz;
	logic [31:0] acc_count;

	least_squares_plane_fit_core dut (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_ready(pt_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last(last),
		.res_valid(res_valid), .res_ready(res_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.offset_d(offset_d), .singular(singular)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic wide_t widen(input logic [63:0] v);
		return {{384{v[63]}}, v};
	endfunction

	function automatic logic [63:0] rounded_root(input wide_t num, input wide_t den);
		wide_t q, r, c;
		logic [63:0] v;
		q = num / den;
		r = '0;
		for (int i = 223; i >= 0; i--) begin
			c = r;
			c[i] = 1'b1;
			if (c * c <= q)
				r = c;
		end
		if (r[447:64] != 0)
			return 64'd1 << 40;
		v = r[63:0];
		if (v > (64'd1 << 41))
			v = 64'd1 << 41;
		return (v + 64'd1) >> 1;
	endfunction

	function automatic logic [31:0] with_sign(input logic [63:0] mag, input bit neg);
		logic [63:0] v;
		v = neg ? (64'd0 - mag) : mag;
		return v[31:0];
	endfunction

	function automatic bit is_pos(input wide_t v);
		return !v[447] && v != 0;
	endfunction

	function automatic wide_t centered(input wide_t n, input logic [63:0] spq,
			input logic [63:0] sp, input logic [63:0] sq);
		return n * widen(spq) - widen(sp) * widen(sq);
	endfunction

	function automatic plane_t solve_plane();
		plane_t p;
		wide_t n, cyy, cyz, czz, cxy, cxz, dd, aa, bb, r2, sc, num;
		logic [63:0] mag;
		bit neg;
		n = wide_t'(acc_count);
		cyy = centered(n, acc_yy, acc_y, acc_y);
		cyz = centered(n, acc_yz, acc_y, acc_z);
		czz = centered(n, acc_zz, acc_z, acc_z);
		cxy = centered(n, acc_xy, acc_x, acc_y);
		cxz = centered(n, acc_xz, acc_x, acc_z);
		dd = cyy * czz - cyz * cyz;
		if (!is_pos(dd)) begin
			p = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
			return p;
		end
		aa = cxy * czz - cxz * cyz;
		bb = cxz * cyy - cxy * cyz;
		r2 = dd * dd + aa * aa + bb * bb;
		sc = wide_t'(1) << (2 * lspf_pkg::NORMAL_FRAC + 2);
		p.nx = with_sign(rounded_root(dd * dd * sc, r2), 1'b0);
		p.ny = with_sign(rounded_root(aa * aa * sc, r2), is_pos(aa));
		p.nz = with_sign(rounded_root(bb * bb * sc, r2), is_pos(bb));
		num = dd * widen(acc_x) - aa * widen(acc_y) - bb * widen(acc_z);
		neg = is_pos(num);
		mag = rounded_root(num * num * 4, n * n * r2);
		if (neg && mag > 64'h8000_0000)
			mag = 64'h8000_0000;
		if (!neg && mag > 64'h7FFF_FFFF)
			mag = 64'h7FFF_FFFF;
		p.d = with_sign(mag, neg);
		p.sing = 1'b0;
		return p;
	endfunction

	function automatic void clear_sums();
		{acc_x, acc_y, acc_z, acc_yy, acc_yz, acc_zz, acc_xy, acc_xz} = '0;
		acc_count = '0;
	endfunction

	function automatic void accept_point(input logic [19:0] x, input logic [19:0] y,
			input logic [19:0] z, input logic lst);
		logic [63:0] xe, ye, ze;
		xe = {{44{x[19]}}, x};
		ye = {{44{y[19]}}, y};
		ze = {{44{z[19]}}, z};
		if (acc_count < (32'd1 << lspf_pkg::COUNT_BITS)) begin
			acc_x += xe;
			acc_y += ye;
			acc_z += ze;
			acc_yy += ye * ye;
			acc_yz += ye * ze;
			acc_zz += ze * ze;
			acc_xy += xe * ye;
			acc_xz += xe * ze;
			acc_count++;
		end
		if (lst) begin
			plane_q.insert(plane_q.size(), solve_plane());
			clear_sums();
		end
	endfunction

	task automatic send_point(input logic [19:0] x, input logic [19:0] y,
			input logic [19:0] z, input logic lst);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pt_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		last <= lst;
		do
			@(posedge clk);
		while (!pt_ready);
		accept_point(x, y, z, lst);
	endtask

	task automatic drain();
		pt_valid <= 1'b0;
		while (plane_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [19:0] clamp20(input longint v);
		if (v > 524287)
			return 20'd524287;
		if (v < -524288)
			return 20'h80000;
		return v[19:0];
	endfunction

	task automatic send_cloud(input cloud_kind_t kind, input int size);
		int span, ka, kb, c;
		longint y, z, x;
		span = (1 << $urandom_range(1, 19)) - 1;
		ka = $urandom_range(0, 128) - 64;
		kb = $urandom_range(0, 128) - 64;
		c = $urandom_range(0, 1048575) - 524288;
		for (int i = 0; i < size; i++) begin
			y = longint'($urandom_range(0, 2 * span)) - span;
			z = longint'($urandom_range(0, 2 * span)) - span;
			x = (ka * y + kb * z) / 16 + c + longint'($urandom_range(0, 6)) - 3;
			case (kind)
				CLOUD_PLANAR:
					send_point(clamp20(x), clamp20(y), clamp20(z), i == size - 1);
				CLOUD_UNIFORM:
					send_point(20'($urandom), 20'($urandom), 20'($urandom), i == size - 1);
				CLOUD_LINE:
					send_point(clamp20(x), clamp20(y), clamp20(y), i == size - 1);
				default:
					send_point({1'($urandom_range(0, 1)), {19{i[0]}}},
						{i[1], {19{~i[1]}}}, {i[2], {19{~i[2]}}}, i == size - 1);
			endcase
		end
	endtask

	task automatic test_extremes();
		send_cloud(CLOUD_CORNERS, 8);
		send_cloud(CLOUD_CORNERS, 16);
		send_point(20'h80000, 20'h80000, 20'h80000, 1'b0);
		send_point(20'h7FFFF, 20'h7FFFF, 20'h80000, 1'b0);
		send_point(20'h80000, 20'h80000, 20'h7FFFF, 1'b0);
		send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b1);
		drain();
	endtask

	task automatic test_singular();
		send_point(20'd5, 20'd6, 20'd7, 1'b1);
		send_point(20'd1, 20'd2, 20'd3, 1'b0);
		send_point(20'd4, 20'd2, 20'd3, 1'b1);
		send_cloud(CLOUD_LINE, 6);
		send_point(20'd0, 20'd0, 20'd0, 1'b0);
		send_point(20'd0, 20'd1, 20'd0, 1'b0);
		send_point(20'd0, 20'd0, 20'd1, 1'b1);
		drain();
	endtask

	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		send_cloud(CLOUD_PLANAR, 5);
		send_cloud(CLOUD_PLANAR, 4);
		send_cloud(CLOUD_UNIFORM, 6);
		drain();
	endtask

	task automatic test_random();
		int sent, size, pick;
		sent = 0;
		while (sent < 1250) begin
			if (sent > 1000)
				quiet = 1'b1;
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 55);
			pick = $urandom_range(0, 9);
			send_cloud(pick < 6 ? CLOUD_PLANAR : pick < 9 ? CLOUD_UNIFORM : CLOUD_LINE, size);
			sent += size;
		end
		drain();
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : receiver
		int gap;
		gap = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				res_ready <= 1'b0;
				hold_request--;
			end else if (gap > 0) begin
				res_ready <= 1'b0;
				gap--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				gap = $urandom_range(0, 3);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		plane_t e;
		if (arst_n && res_valid && res_ready) begin
			if (plane_q.size() == 0) begin
				$display("%0t: unexpected result nx=%h ny=%h nz=%h d=%h sing=%b", $time,
					normal_x, normal_y, normal_z, offset_d, singular);
				fail_count++;
			end else begin
				e = plane_q.pop_front();
				if (normal_x !== e.nx) begin
					$display("%0t: normal_x expected %h actual %h", $time, e.nx, normal_x);
					fail_count++;
				end
				if (normal_y !== e.ny) begin
					$display("%0t: normal_y expected %h actual %h", $time, e.ny, normal_y);
					fail_count++;
				end
				if (normal_z !== e.nz) begin
					$display("%0t: normal_z expected %h actual %h", $time, e.nz, normal_z);
					fail_count++;
				end
				if (offset_d !== e.d) begin
					$display("%0t: offset_d expected %h actual %h", $time, e.d, offset_d);
					fail_count++;
				end
				if (singular !== e.sing) begin
					$display("%0t: singular expected %b actual %b", $time, e.sing, singular);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pt_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		last = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		quiet = 1'b0;
		hold_request = 0;
		clear_sums();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_singular();
		test_backpressure();
		test_random();
		repeat (50) @(posedge clk);
		if (plane_q.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
